// ----- src/pwbc_pkg.sv -----
`default_nettype none

package pwbc_pkg;

    // One input word: field order follows the channel definition, first field in the MSBs.
    typedef struct packed {
        logic        operation;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [14:0] color_bgr555;
        logic [2:0]  layer_index;
        logic [5:0]  window_mask;
        logic [4:0]  brightness_coeff;
        logic        force_alpha;
    } in_item_t;

    typedef struct packed {
        logic [23:0] rgb_out;
        logic [2:0]  layer_out;
        logic        written;
    } out_item_t;

    // One frame store entry. A cleared entry is all zero and therefore not valid.
    typedef struct packed {
        logic        valid;
        logic [2:0]  layer;
        logic [23:0] color;
    } entry_t;

    typedef enum logic [1:0] {
        FX_NONE     = 2'd0,
        FX_ALPHA    = 2'd1,
        FX_BRIGHTEN = 2'd2,
        FX_DARKEN   = 2'd3
    } effect_t;

    // Effect settings as seen by the pixel datapath; alphas are already saturated at 16.
    typedef struct packed {
        effect_t    effect;
        logic [5:0] source_targets;
        logic [5:0] dest_targets;
        logic [4:0] alpha_top;
        logic [4:0] alpha_bottom;
    } fx_cfg_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [2:0] REG_BLEND_EFFECT   = 3'd0;
    localparam logic [2:0] REG_SOURCE_TARGETS = 3'd1;
    localparam logic [2:0] REG_DEST_TARGETS   = 3'd2;
    localparam logic [2:0] REG_ALPHA_TOP      = 3'd3;
    localparam logic [2:0] REG_ALPHA_BOTTOM   = 3'd4;

    localparam logic [2:0] BACKDROP_LAYER = 3'd5;
    localparam int         EFFECTS_BIT    = 5;
    localparam logic [4:0] COEFF_MAX      = 5'd16;

    // floor(c * 255 / 31) for every 5-bit channel value.
    localparam logic [7:0] EXPAND5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // Bit of a per-layer mask; layers six and seven have no bit and read as zero.
    function automatic logic layer_hit(logic [5:0] mask, logic [2:0] layer);
        logic [7:0] ext;
        ext = {2'b00, mask};
        return ext[layer];
    endfunction

    function automatic logic [4:0] sat16(logic [4:0] v);
        return (v > COEFF_MAX) ? COEFF_MAX : v;
    endfunction

    function automatic logic [23:0] expand555(logic [14:0] c);
        return {EXPAND5[c[14:10]], EXPAND5[c[9:5]], EXPAND5[c[4:0]]};
    endfunction

endpackage

`default_nettype wire

// ----- src/pwbc_effect.sv -----
`default_nettype none

// Window test and color effect for one pixel against the entry stored below it.
module pwbc_effect
    import pwbc_pkg::*;
(
    input  var fx_cfg_t     cfg,
    input  wire logic [23:0] color,
    input  wire logic [2:0]  layer,
    input  wire logic [5:0]  mask,
    input  wire logic [4:0]  evy,
    input  wire logic        force_alpha,
    input  var entry_t      below,
    output logic            visible,
    output logic [23:0]     color_out
);

    logic forced;
    logic is_source;
    logic apply;
    logic below_dest;

    assign visible    = (layer == BACKDROP_LAYER) || layer_hit(mask, layer);
    assign forced     = force_alpha && (cfg.effect == FX_ALPHA);
    assign is_source  = layer_hit(cfg.source_targets, layer) || forced;
    assign apply      = (mask[EFFECTS_BIT] || forced) && is_source && (cfg.effect != FX_NONE);
    assign below_dest = below.valid && layer_hit(cfg.dest_targets, below.layer);

    always_comb begin
        logic [7:0]  x;
        logic [7:0]  b;
        logic [12:0] prod_up;
        logic [12:0] prod_dn;
        logic [13:0] mix;
        logic [9:0]  mix_sh;
        logic [7:0]  res;
        color_out = color;
        for (int i = 0; i < 3; i++) begin
            x       = color[8*i +: 8];
            b       = below.color[8*i +: 8];
            prod_up = {5'b0, ~x} * {8'b0, evy};
            prod_dn = {5'b0, x} * {8'b0, evy};
            mix     = {6'b0, x} * {9'b0, cfg.alpha_top} + {6'b0, b} * {9'b0, cfg.alpha_bottom};
            mix_sh  = mix[13:4];
            res     = x;
            if (apply) begin
                case (cfg.effect)
                    FX_BRIGHTEN: res = x + prod_up[11:4];
                    FX_DARKEN:   res = x - prod_dn[11:4];
                    FX_ALPHA: begin
                        if (below_dest) begin
                            res = (|mix_sh[9:8]) ? 8'hFF : mix_sh[7:0];
                        end
                    end
                    default:     res = x;
                endcase
            end
            color_out[8*i +: 8] = res;
        end
    end

endmodule

`default_nettype wire

// ----- src/pixel_window_blend_compositor.sv -----
`default_nettype none

// Channel   | Ports                                   | Word
// ----------+-----------------------------------------+---------------------------
// input     | s_valid, s_ready, s_item                | in_item_t, one pixel op
// result    | m_valid, m_ready, m_item                | out_item_t, one per input
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | register index and value
//
// One word is accepted per clock unless the pipeline stalls; its result word is offered from
// the result register once it has passed the compose stage. The frame store is one
// synchronous RAM: a write word reads its entry in the accept cycle and writes it back as it
// leaves the compose stage, and a forwarding register covers a read that hits that write-back.
// After reset a clearing pass zeroes every entry, one per clock; s_ready stays low meanwhile.
// The pipeline stalls only when the result register is full and m_ready is low.
module pixel_window_blend_compositor
    import pwbc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 160
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  var in_item_t    s_item,

    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_item,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [5:0] cfg_data
);

    localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(PIXELS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);

    // Effect registers. The alpha weights are saturated at 16 as they are written.
    fx_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BLEND_EFFECT:   cfg_reg.effect         <= effect_t'(cfg_data[1:0]);
                REG_SOURCE_TARGETS: cfg_reg.source_targets <= cfg_data;
                REG_DEST_TARGETS:   cfg_reg.dest_targets   <= cfg_data;
                REG_ALPHA_TOP:      cfg_reg.alpha_top      <= sat16(cfg_data[4:0]);
                REG_ALPHA_BOTTOM:   cfg_reg.alpha_bottom   <= sat16(cfg_data[4:0]);
                default: ;
            endcase
        end
    end

    // Clearing pass: every entry is zeroed once after reset, which also drops its valid bit.
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_count_reg <= '0;
        end else if (clearing_reg) begin
            clr_count_reg <= clr_count_reg + 1'b1;
            if (clr_count_reg == LAST_ADDR) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Accept stage: bounds check, address and color expansion.
    logic              s_fire;
    logic              s_onscreen;
    logic [ADDR_W-1:0] s_addr;

    assign s_fire     = s_valid && s_ready;
    assign s_onscreen = (32'(s_item.pixel_x) < SCREEN_WIDTH) &&
                        (32'(s_item.pixel_y) < SCREEN_HEIGHT);
    assign s_addr     = s_onscreen ?
                        ADDR_W'(32'(s_item.pixel_y) * SCREEN_WIDTH + 32'(s_item.pixel_x)) : '0;

    // Compose stage registers.
    logic              p1_valid_reg;
    logic              p1_onscreen_reg;
    logic              p1_op_reg;
    logic [ADDR_W-1:0] p1_addr_reg;
    logic [23:0]       p1_color_reg;
    logic [2:0]        p1_layer_reg;
    logic [5:0]        p1_mask_reg;
    logic [4:0]        p1_evy_reg;
    logic              p1_force_reg;

    // Frame store and its read data, plus the forwarding register for a same-cycle write.
    entry_t            mem [PIXELS];
    entry_t            rdata_reg;
    entry_t            fwd_data_reg;
    logic              fwd_hit_reg;

    logic              m_valid_reg;
    out_item_t         m_item_reg;

    logic              p1_adv;
    logic              visible;
    logic [23:0]       new_color;
    logic              store;
    logic              pix_we;
    entry_t            below;
    entry_t            new_entry;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    out_item_t         result;

    assign below = fwd_hit_reg ? fwd_data_reg : rdata_reg;

    pwbc_effect u_effect (
        .cfg         (cfg_reg),
        .color       (p1_color_reg),
        .layer       (p1_layer_reg),
        .mask        (p1_mask_reg),
        .evy         (p1_evy_reg),
        .force_alpha (p1_force_reg),
        .below       (below),
        .visible     (visible),
        .color_out   (new_color)
    );

    assign p1_adv    = p1_valid_reg && (!m_valid_reg || m_ready);
    assign store     = p1_onscreen_reg && (p1_op_reg == OP_WRITE) && visible;
    assign pix_we    = p1_adv && store;
    assign new_entry = '{valid: 1'b1, layer: p1_layer_reg, color: new_color};

    assign mem_we    = clearing_reg || pix_we;
    assign mem_waddr = clearing_reg ? clr_count_reg : p1_addr_reg;
    assign mem_wdata = clearing_reg ? entry_t'('0) : new_entry;

    assign s_ready   = !clearing_reg && (!p1_valid_reg || p1_adv);

    always_comb begin
        result = '0;
        if (store) begin
            result.rgb_out   = new_color;
            result.layer_out = p1_layer_reg;
            result.written   = 1'b1;
        end else if (p1_onscreen_reg) begin
            result.rgb_out   = below.color;
            result.layer_out = below.layer;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (s_fire) begin
            rdata_reg <= mem[s_addr];
        end
    end

    // A read that sees the write-back of the word ahead of it returns stale data from the RAM.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (s_fire) begin
            fwd_hit_reg <= pix_we && s_onscreen && (s_addr == p1_addr_reg);
        end else if (p1_adv) begin
            fwd_hit_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fwd_data_reg <= new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_onscreen_reg <= s_onscreen;
            p1_op_reg       <= s_item.operation;
            p1_addr_reg     <= s_addr;
            p1_color_reg    <= expand555(s_item.color_bgr555);
            p1_layer_reg    <= s_item.layer_index;
            p1_mask_reg     <= s_item.window_mask;
            p1_evy_reg      <= sat16(s_item.brightness_coeff);
            p1_force_reg    <= s_item.force_alpha;
        end
    end

    // Result register: while a finished word waits here unaccepted, the compose stage holds its word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // The pipeline stays empty for the whole clearing pass.
    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !p1_valid_reg && !m_valid_reg)
        else $error("pixel word in flight during clearing pass");

    // The clearing pass ends only after the last entry was written.
    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> $past(clr_count_reg) == LAST_ADDR)
        else $error("clearing pass ended early");

    // Forwarding applies only to a word that is in the compose stage.
    a_fwd_live: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> p1_valid_reg)
        else $error("forward hit without a word in the compose stage");

    // A stored pixel always belongs to one of the six real layers.
    a_written_layer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.written |-> m_item_reg.layer_out <= BACKDROP_LAYER)
        else $error("written pixel carries an invalid layer");

endmodule

`default_nettype wire

// ----- tb/pixel_window_blend_compositor_test.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the pixel compositor. A queue of pixel words feeds a clocked
// driver, every accepted word is run through a local model of the frame store and the
// blend pipeline, and a clocked monitor compares each result word with the oldest
// prediction. Effect settings change only while the pipeline is empty.
module pixel_window_blend_compositor_test;
    import pwbc_pkg::*;

    localparam int SCREEN_W = 240;
    localparam int SCREEN_H = 160;
    localparam int PIXELS = SCREEN_W * SCREEN_H;

    // The clearing pass after reset runs with no handshake at all, so the no-progress limit sits
    // several times above the number of pixels in the frame store.
    localparam int IDLE_LIMIT = 160000;
    // Length of the deliberate result back-pressure stretch, in cycles.
    localparam int LONG_HOLD = 64;
    // Beyond this many errors the run keeps counting but stops printing.
    localparam int PRINT_LIMIT = 60;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_item = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [5:0] cfg_data = '0;

    // Model of the frame store. Two-state arrays start at zero, which is the reset state.
    bit [23:0] frame_color [PIXELS];
    bit [2:0]  frame_layer [PIXELS];
    bit        frame_valid [PIXELS];

    // Model copy of the effect registers, updated when a register write is accepted.
    effect_t  fx_mode = FX_NONE;
    bit [5:0] source_mask = '0;
    bit [5:0] dest_mask = '0;
    bit [4:0] top_weight = '0;
    bit [4:0] bottom_weight = '0;

    in_item_t  pending_pixels [$];
    out_item_t expected_pixels [$];
    out_item_t oldest_pixel;

    int errors = 0;
    // When clear, both sides run without random gaps.
    bit idling_on = 1'b1;
    // Bumped by the stimulus to ask the monitor for one long stretch of back-pressure.
    int hold_requests = 0;

    int send_wait = 0;
    int take_wait = 0;
    int hold_left = 0;
    int holds_served = 0;
    int idle_cycles = 0;

    pixel_window_blend_compositor #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 aclk = ~aclk;

    task automatic log_error(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Coefficients are five bits wide but only mean something up to sixteen sixteenths.
    function automatic int unsigned cap_sixteenths(logic [4:0] v);
        return (v > 5'd16) ? 16 : int'(v);
    endfunction

    // Applies one pixel word to the frame store model and returns the result word it
    // should produce. Off-screen words leave the store alone and return all zero.
    function automatic out_item_t composite_pixel(in_item_t w);
        out_item_t   r;
        int unsigned idx;
        int unsigned x;
        int unsigned below;
        int unsigned evy;
        int unsigned acc;
        bit [23:0]   rgb;
        bit          visible;
        bit          forced;
        bit          source;
        r = '0;
        if (w.pixel_x >= SCREEN_W || w.pixel_y >= SCREEN_H)
            return r;
        idx = w.pixel_y * SCREEN_W + w.pixel_x;
        if (w.operation == OP_WRITE) begin
            // The backdrop always shows; layers six and seven have no window bit.
            visible = (w.layer_index == BACKDROP_LAYER) ||
                      (w.layer_index < 3'd6 && w.window_mask[w.layer_index]);
            if (visible) begin
                // A semi-transparent object blends even outside an effects window.
                forced = w.force_alpha && fx_mode == FX_ALPHA;
                source = source_mask[w.layer_index] || forced;
                evy = cap_sixteenths(w.brightness_coeff);
                for (int i = 0; i < 3; i++) begin
                    x = int'(w.color_bgr555[i*5 +: 5]) * 255 / 31;
                    if ((w.window_mask[EFFECTS_BIT] || forced) && source &&
                            fx_mode != FX_NONE) begin
                        case (fx_mode)
                            FX_BRIGHTEN: x = x + (((255 - x) * evy) >> 4);
                            FX_DARKEN:   x = x - ((x * evy) >> 4);
                            default: begin
                                // Blending needs a stored pixel below whose layer is a
                                // second target; otherwise the new colour goes in as is.
                                if (frame_valid[idx] && dest_mask[frame_layer[idx]]) begin
                                    below = frame_color[idx][i*8 +: 8];
                                    acc = (x * cap_sixteenths(top_weight) +
                                           below * cap_sixteenths(bottom_weight)) >> 4;
                                    x = (acc > 255) ? 255 : acc;
                                end
                            end
                        endcase
                    end
                    rgb[i*8 +: 8] = x[7:0];
                end
                frame_color[idx] = rgb;
                frame_layer[idx] = w.layer_index;
                frame_valid[idx] = 1'b1;
                r.written = 1'b1;
            end
        end
        r.rgb_out = frame_color[idx];
        r.layer_out = frame_layer[idx];
        return r;
    endfunction

    function automatic in_item_t pixel_word(logic op, int px, int py, logic [14:0] color,
                                            logic [2:0] layer, logic [5:0] mask,
                                            logic [4:0] coeff, logic semi);
        in_item_t w;
        w.operation = op;
        w.pixel_x = 8'(px);
        w.pixel_y = 8'(py);
        w.color_bgr555 = color;
        w.layer_index = layer;
        w.window_mask = mask;
        w.brightness_coeff = coeff;
        w.force_alpha = semi;
        return w;
    endfunction

    // Most words land in a small patch of corner pixels so that writes pile up on top of
    // each other and blending sees a stored pixel below. The rest go anywhere on screen
    // or over the whole eight-bit range, which includes positions off screen.
    function automatic in_item_t random_pixel();
        in_item_t    w;
        int unsigned pick;
        w.operation = ($urandom_range(0, 3) == 0) ? OP_READ : OP_WRITE;
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            w.pixel_x = 8'($urandom_range(0, 1) ? $urandom_range(0, 7) :
                                                  $urandom_range(232, 239));
            w.pixel_y = 8'($urandom_range(0, 1) ? $urandom_range(0, 3) :
                                                  $urandom_range(156, 159));
        end else if (pick == 8) begin
            w.pixel_x = 8'($urandom_range(0, SCREEN_W - 1));
            w.pixel_y = 8'($urandom_range(0, SCREEN_H - 1));
        end else begin
            w.pixel_x = 8'($urandom_range(0, 255));
            w.pixel_y = 8'($urandom_range(0, 255));
        end
        w.color_bgr555 = 15'($urandom_range(0, 32767));
        w.layer_index = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) :
                                                         $urandom_range(0, 5));
        w.window_mask = 6'($urandom_range(0, 63));
        // Lean toward visible layers and open effects windows so the effects get exercised.
        if ($urandom_range(0, 2) != 0)
            w.window_mask[EFFECTS_BIT] = 1'b1;
        if (w.layer_index < 3'd6 && $urandom_range(0, 3) != 0)
            w.window_mask[w.layer_index] = 1'b1;
        w.brightness_coeff = 5'($urandom_range(0, 31));
        w.force_alpha = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Queue updates happen on the falling edge, away from the driver's rising-edge pop.
    task automatic queue_random_pixels(input int count);
        @(negedge aclk);
        repeat (count) pending_pixels.push_back(random_pixel());
    endtask

    // Returns once every queued word has gone in and every result word has come back,
    // then waits for the two-stage pipeline to settle.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_pixels.size() != 0 || s_valid || expected_pixels.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Register writes are one at a time, and cfg_valid is lowered before the next write raises
    // it, so cfg_valid is never lowered and raised in the same step.
    task automatic write_register(input logic [2:0] index, input logic [5:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            REG_BLEND_EFFECT:   fx_mode = effect_t'(value[1:0]);
            REG_SOURCE_TARGETS: source_mask = value;
            REG_DEST_TARGETS:   dest_mask = value;
            REG_ALPHA_TOP:      top_weight = value[4:0];
            REG_ALPHA_BOTTOM:   bottom_weight = value[4:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [5:0] effect, input logic [5:0] src,
                                  input logic [5:0] dst, input logic [5:0] top,
                                  input logic [5:0] bottom);
        write_register(REG_BLEND_EFFECT, effect);
        write_register(REG_SOURCE_TARGETS, src);
        write_register(REG_DEST_TARGETS, dst);
        write_register(REG_ALPHA_TOP, top);
        write_register(REG_ALPHA_BOTTOM, bottom);
    endtask

    // Driver. A word that is offered stays on the port until it is taken. Each word is
    // predicted at the edge that accepts it, so the model always sees the same order as
    // the block. After offering a word the driver draws a random gap while idling is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_valid && s_ready)
                expected_pixels.push_back(composite_pixel(s_item));
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    s_item <= pending_pixels.pop_front();
                    s_valid <= 1'b1;
                    send_wait = idling_on ? $urandom_range(0, 4) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every result word is checked field by field against the oldest
    // prediction. Back-pressure comes from a per-word random wait and, on request, one
    // long hold that lets the pipeline fill and push back on the input side.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    log_error("result word arrived with no prediction waiting");
                end else begin
                    oldest_pixel = expected_pixels.pop_front();
                    if (m_item.rgb_out !== oldest_pixel.rgb_out)
                        log_error($sformatf("rgb_out %06h, expected %06h",
                                            m_item.rgb_out, oldest_pixel.rgb_out));
                    if (m_item.layer_out !== oldest_pixel.layer_out)
                        log_error($sformatf("layer_out %0d, expected %0d",
                                            m_item.layer_out, oldest_pixel.layer_out));
                    if (m_item.written !== oldest_pixel.written)
                        log_error($sformatf("written %0b, expected %0b",
                                            m_item.written, oldest_pixel.written));
                end
                take_wait = idling_on ? $urandom_range(0, 4) : 0;
            end
            if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (take_wait > 0) begin
                take_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a long run of cycles with no word moving on any channel means a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings, no effect selected. Covers an unwritten pixel, the backdrop
        // ignoring the window, a hidden layer, layers six and seven, the far corner and
        // positions just off screen in both directions.
        @(negedge aclk);
        pending_pixels.push_back(pixel_word(OP_READ,    0,   0, 15'h0000, 3'd0, 6'h00, 5'd0,  1'b0));
        pending_pixels.push_back(pixel_word(OP_WRITE,   0,   0, 15'h7fff, 3'd5, 6'h00, 5'd0,  1'b0));
        pending_pixels.push_back(pixel_word(OP_WRITE,   0,   0, 15'h0000, 3'd0, 6'h00, 5'd0,  1'b0));
        pending_pixels.push_back(pixel_word(OP_WRITE,   1,   0, 15'h5555, 3'd6, 6'h3f, 5'd0,  1'b0));
        pending_pixels.push_back(pixel_word(OP_WRITE,   1,   0, 15'h2aaa, 3'd7, 6'h3f, 5'd0,  1'b1));
        pending_pixels.push_back(pixel_word(OP_WRITE, 239, 159, 15'h7c1f, 3'd4, 6'h3f, 5'd31, 1'b1));
        pending_pixels.push_back(pixel_word(OP_WRITE, 240,   0, 15'h7fff, 3'd5, 6'h3f, 5'd0,  1'b0));
        pending_pixels.push_back(pixel_word(OP_READ,    0, 160, 15'h0000, 3'd0, 6'h00, 5'd0,  1'b0));
        pending_pixels.push_back(pixel_word(OP_WRITE, 255, 255, 15'h7fff, 3'd0, 6'h3f, 5'd16, 1'b1));
        pending_pixels.push_back(pixel_word(OP_READ,  239, 159, 15'h0000, 3'd0, 6'h00, 5'd0,  1'b0));
        wait_drained();

        // Alpha blend with the top weight above sixteen: blending onto a never-stored
        // pixel, clamping white over white, effects window closed, and a semi-transparent
        // object forcing the blend outside the effects window.
        apply_settings(6'(FX_ALPHA), 6'h3f, 6'h3f, 6'd31, 6'd16);
        @(negedge aclk);
        pending_pixels.push_back(pixel_word(OP_WRITE, 2, 0, 15'h1234, 3'd1, 6'h3f, 5'd0, 1'b0));
        pending_pixels.push_back(pixel_word(OP_WRITE, 0, 0, 15'h7fff, 3'd0, 6'h21, 5'd0, 1'b0));
        pending_pixels.push_back(pixel_word(OP_WRITE, 0, 0, 15'h1234, 3'd2, 6'h04, 5'd0, 1'b0));
        pending_pixels.push_back(pixel_word(OP_WRITE, 3, 0, 15'h03e0, 3'd5, 6'h00, 5'd0, 1'b0));
        pending_pixels.push_back(pixel_word(OP_WRITE, 3, 0, 15'h7c00, 3'd4, 6'h10, 5'd0, 1'b1));
        queue_random_pixels(150);
        wait_drained();

        // Brighten at the top, middle and bottom of the coefficient range. This phase
        // runs without gaps and starts with a long result hold so the input stalls.
        apply_settings(6'(FX_BRIGHTEN), 6'h3f, 6'h00, 6'd0, 6'd0);
        @(negedge aclk);
        idling_on = 1'b0;
        hold_requests++;
        pending_pixels.push_back(pixel_word(OP_WRITE, 4, 0, 15'h4210, 3'd3, 6'h3f, 5'd31, 1'b0));
        pending_pixels.push_back(pixel_word(OP_WRITE, 4, 0, 15'h4210, 3'd3, 6'h3f, 5'd16, 1'b0));
        pending_pixels.push_back(pixel_word(OP_WRITE, 4, 0, 15'h4210, 3'd3, 6'h3f, 5'd0,  1'b0));
        queue_random_pixels(150);
        wait_drained();

        // Darken with split target masks. Halfway through, the sender stops until every
        // result has come back, then resumes with the same settings.
        apply_settings(6'(FX_DARKEN), 6'h15, 6'h2a, 6'd16, 6'd0);
        @(negedge aclk);
        idling_on = 1'b1;
        pending_pixels.push_back(pixel_word(OP_WRITE, 5, 0, 15'h7fff, 3'd0, 6'h3f, 5'd31, 1'b0));
        pending_pixels.push_back(pixel_word(OP_WRITE, 5, 0, 15'h7fff, 3'd2, 6'h3f, 5'd8,  1'b0));
        queue_random_pixels(75);
        wait_drained();
        queue_random_pixels(75);
        wait_drained();

        // Alpha with no first targets and both weights zero: only forced objects blend,
        // and they blend to black.
        apply_settings(6'(FX_ALPHA), 6'h00, 6'h3f, 6'd0, 6'd0);
        @(negedge aclk);
        idling_on = 1'b0;
        pending_pixels.push_back(pixel_word(OP_WRITE, 0, 0, 15'h7fff, 3'd4, 6'h10, 5'd0, 1'b1));
        queue_random_pixels(150);
        wait_drained();

        // Random settings over the full width of the data port, alternating between
        // gapped and gap-free traffic.
        for (int phase = 0; phase < 6; phase++) begin
            apply_settings(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                           6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                           6'($urandom_range(0, 63)));
            @(negedge aclk);
            idling_on = phase[0];
            queue_random_pixels(150);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (expected_pixels.size() != 0)
            log_error($sformatf("%0d predictions never matched by a result word",
                                expected_pixels.size()));
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
